[rtl/maa_pkg.sv]
// Shared types and constants for the multiplet asymmetry accumulator.
package maa_pkg;

    localparam int TOTAL_BITS    = 27;
    localparam int DIFF_BITS     = 28;
    localparam int AVG_BITS      = 25;
    localparam int Q_BITS        = 17;
    localparam int Q_STEPS       = 16;
    localparam int PROD_BITS     = 54;
    localparam int DIV_BITS      = 56;
    localparam int AVG_STEPS     = DIFF_BITS;
    localparam int STEP_BITS     = 5;
    localparam int CFG_BITS      = 4;
    localparam int MIN_PAIRS     = 2;
    localparam int CFG_RESET     = 2;
    localparam int STATUS_BITS   = 2;
    localparam int IN_USER_BITS  = 3;
    localparam int OUT_DATA_BITS = 96;

    localparam logic [Q_BITS-1:0] Q_MINUS_ONE = 17'h10000;
    localparam logic [Q_BITS-1:0] Q_MAX       = 17'h0FFFF;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_PARTIAL     = 2'd0,
        ST_COMPLETE    = 2'd1,
        ST_NO_FIRST    = 2'd2,
        ST_EXTRA_FIRST = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_A,
        S_MUL_B,
        S_PREP,
        S_LD_ASY,
        S_DIV_ASY,
        S_LD_NASY,
        S_DIV_NASY,
        S_DONE
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_MUL_A,
        OP_MUL_B,
        OP_PREP,
        OP_LD_ASY,
        OP_LD_NASY,
        OP_STEP,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic complete;
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage

[rtl/maa_ctrl.sv]
// Controller state machine sequencing accumulate, multiply and divide steps.
module maa_ctrl
    import maa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:    state_next = stat.complete ? S_MUL_A : S_DONE;
            S_MUL_A:    state_next = S_MUL_B;
            S_MUL_B:    state_next = S_PREP;
            S_PREP:     state_next = S_LD_ASY;
            S_LD_ASY:   state_next = S_DIV_ASY;
            S_DIV_ASY:
            begin
                if (stat.div_last)
                begin
                    state_next = S_LD_NASY;
                end
            end
            S_LD_NASY:  state_next = S_DIV_NASY;
            S_DIV_NASY:
            begin
                if (stat.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NONE;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op = OP_ACCEPT;
                end
            end
            S_MUL_A:    cmd.op = OP_MUL_A;
            S_MUL_B:    cmd.op = OP_MUL_B;
            S_PREP:     cmd.op = OP_PREP;
            S_LD_ASY:   cmd.op = OP_LD_ASY;
            S_DIV_ASY:  cmd.op = OP_STEP;
            S_LD_NASY:  cmd.op = OP_LD_NASY;
            S_DIV_NASY: cmd.op = OP_STEP;
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_OUT;
                end
            end
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

[rtl/maa_datapath.sv]
// Datapath: totals, shared multiplier, Q1.16 divider, average divider, output word.
module maa_datapath
    import maa_pkg::*;
#(
    parameter int MAX_PAIRS  = 8,
    parameter int VALUE_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dp_cmd_t                       cmd,
    output dp_stat_t                      stat,
    input  logic                          cfg_we,
    input  logic [CFG_BITS-1:0]           cfg_data,
    input  logic                          first_mark,
    input  logic signed [VALUE_BITS-1:0]  right_value,
    input  logic signed [VALUE_BITS-1:0]  left_value,
    input  logic signed [VALUE_BITS-1:0]  right_monitor,
    input  logic signed [VALUE_BITS-1:0]  left_monitor,
    input  logic                          pair_passed,
    input  logic                          pair_beam_cut,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output status_t                       status,
    output logic signed [DIFF_BITS-1:0]   difference,
    output logic signed [AVG_BITS-1:0]    average_half,
    output logic signed [Q_BITS-1:0]      asymmetry,
    output logic signed [Q_BITS-1:0]      norm_asymmetry,
    output logic                          all_passed,
    output logic                          any_beam_cut,
    output logic                          bad_denominator
);

    localparam int NW = $clog2(MAX_PAIRS + 1);
    localparam int SW = ((VALUE_BITS > TOTAL_BITS) ? VALUE_BITS : TOTAL_BITS) + 1;

    function automatic logic signed [TOTAL_BITS-1:0] sat_total(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = {{(SW-TOTAL_BITS+1){1'b0}}, {(TOTAL_BITS-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
        begin
            return hi[TOTAL_BITS-1:0];
        end
        else if (v < lo)
        begin
            return lo[TOTAL_BITS-1:0];
        end
        return v[TOTAL_BITS-1:0];
    endfunction

    function automatic logic [Q_BITS-1:0] q_final(input logic forced, input logic ovf,
                                                  input logic neg, input logic [Q_STEPS-1:0] q);
        logic [Q_BITS-1:0] qe;
        qe = {1'b0, q};
        if (forced)
        begin
            return Q_MINUS_ONE;
        end
        else if (ovf)
        begin
            return neg ? Q_MINUS_ONE : Q_MAX;
        end
        return neg ? Q_BITS'(-qe) : qe;
    endfunction

    // configuration and totals
    logic [CFG_BITS-1:0]          cfg_reg;
    logic [NW-1:0]                count_reg;
    logic signed [TOTAL_BITS-1:0] r_tot_reg, l_tot_reg, rm_tot_reg, lm_tot_reg;
    logic                         cuts_ok_reg, beam_seen_reg;
    status_t                      status_reg;

    logic [NW-1:0]                n_eff;
    logic                         restart, add_ok;
    logic [NW-1:0]                base_cnt, cnt_inc;
    logic signed [TOTAL_BITS-1:0] base_r, base_l, base_rm, base_lm;
    status_t                      status_next;

    always_comb
    begin
        if (int'(cfg_reg) < MIN_PAIRS)
        begin
            n_eff = NW'(MIN_PAIRS);
        end
        else if (int'(cfg_reg) > MAX_PAIRS)
        begin
            n_eff = NW'(MAX_PAIRS);
        end
        else
        begin
            n_eff = NW'(cfg_reg);
        end
    end

    assign restart  = (count_reg == '0) || (count_reg >= n_eff);
    assign add_ok   = restart ? first_mark : !first_mark;
    assign base_cnt = restart ? '0 : count_reg;
    assign base_r   = restart ? '0 : r_tot_reg;
    assign base_l   = restart ? '0 : l_tot_reg;
    assign base_rm  = restart ? '0 : rm_tot_reg;
    assign base_lm  = restart ? '0 : lm_tot_reg;
    assign cnt_inc  = base_cnt + NW'(1);

    always_comb
    begin
        if (!add_ok)
        begin
            status_next = restart ? ST_NO_FIRST : ST_EXTRA_FIRST;
        end
        else if (cnt_inc == n_eff)
        begin
            status_next = ST_COMPLETE;
        end
        else
        begin
            status_next = ST_PARTIAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_BITS'(CFG_RESET);
            count_reg     <= '0;
            r_tot_reg     <= '0;
            l_tot_reg     <= '0;
            rm_tot_reg    <= '0;
            lm_tot_reg    <= '0;
            cuts_ok_reg   <= 1'b1;
            beam_seen_reg <= 1'b0;
            status_reg    <= ST_PARTIAL;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
            if (cmd.op == OP_ACCEPT)
            begin
                status_reg <= status_next;
                if (add_ok)
                begin
                    count_reg     <= cnt_inc;
                    r_tot_reg     <= sat_total(SW'(base_r) + SW'(right_value));
                    l_tot_reg     <= sat_total(SW'(base_l) + SW'(left_value));
                    rm_tot_reg    <= sat_total(SW'(base_rm) + SW'(right_monitor));
                    lm_tot_reg    <= sat_total(SW'(base_lm) + SW'(left_monitor));
                    cuts_ok_reg   <= (restart || cuts_ok_reg) && pair_passed;
                    beam_seen_reg <= (!restart && beam_seen_reg) || pair_beam_cut;
                end
                else if (restart)
                begin
                    count_reg     <= '0;
                    r_tot_reg     <= '0;
                    l_tot_reg     <= '0;
                    rm_tot_reg    <= '0;
                    lm_tot_reg    <= '0;
                    cuts_ok_reg   <= 1'b1;
                    beam_seen_reg <= 1'b0;
                end
            end
        end
    end

    logic signed [DIFF_BITS-1:0] diff_w, sum_w;
    assign diff_w = DIFF_BITS'(r_tot_reg) - DIFF_BITS'(l_tot_reg);
    assign sum_w  = DIFF_BITS'(r_tot_reg) + DIFF_BITS'(l_tot_reg);

    // shared multiplier and normalized numerator/denominator
    logic signed [TOTAL_BITS-1:0] mul_x, mul_y;
    logic signed [PROD_BITS-1:0]  mul_p, prod_a_reg, prod_b_reg;
    logic signed [DIV_BITS-1:0]   num_reg, den_reg, pa, pb;

    assign mul_x = (cmd.op == OP_MUL_A) ? r_tot_reg : l_tot_reg;
    assign mul_y = (cmd.op == OP_MUL_A) ? lm_tot_reg : rm_tot_reg;
    assign mul_p = mul_x * mul_y;
    assign pa    = DIV_BITS'(prod_a_reg);
    assign pb    = DIV_BITS'(prod_b_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_MUL_A)
        begin
            prod_a_reg <= mul_p;
        end
        if (cmd.op == OP_MUL_B)
        begin
            prod_b_reg <= mul_p;
        end
        if (cmd.op == OP_PREP)
        begin
            if (rm_tot_reg[TOTAL_BITS-1] ^ lm_tot_reg[TOTAL_BITS-1])
            begin
                num_reg <= pb - pa;
                den_reg <= -(pa + pb);
            end
            else
            begin
                num_reg <= pa - pb;
                den_reg <= pa + pb;
            end
        end
    end

    // Q1.16 restoring divider
    logic signed [DIV_BITS-1:0] ld_num, ld_den;
    logic                       ld_forced;
    logic [DIV_BITS-1:0]        ld_mag;
    logic [DIV_BITS-1:0]        div_rem_reg, div_den_reg, rem2;
    logic [Q_STEPS-1:0]         div_q_reg, q_next;
    logic [STEP_BITS-1:0]       div_cnt_reg;
    logic                       div_neg_reg, div_ovf_reg, div_forced_reg, div_norm_reg;
    logic                       ge;
    logic [Q_BITS-1:0]          asy_reg, nasy_reg, q_res;

    always_comb
    begin
        if (cmd.op == OP_LD_NASY)
        begin
            ld_num    = num_reg;
            ld_den    = den_reg;
            ld_forced = (rm_tot_reg == '0) || (lm_tot_reg == '0) || (den_reg <= 0);
        end
        else
        begin
            ld_num    = DIV_BITS'(diff_w);
            ld_den    = DIV_BITS'(sum_w);
            ld_forced = (sum_w <= 0);
        end
        ld_mag = ld_num[DIV_BITS-1] ? DIV_BITS'(-ld_num) : DIV_BITS'(ld_num);
    end

    assign rem2   = {div_rem_reg[DIV_BITS-2:0], 1'b0};
    assign ge     = rem2 >= div_den_reg;
    assign q_next = {div_q_reg[Q_STEPS-2:0], ge};
    assign q_res  = q_final(div_forced_reg, div_ovf_reg, div_neg_reg, q_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if ((cmd.op == OP_LD_ASY) || (cmd.op == OP_LD_NASY))
        begin
            div_cnt_reg <= STEP_BITS'(Q_STEPS);
        end
        else if ((cmd.op == OP_STEP) && (div_cnt_reg != '0))
        begin
            div_cnt_reg <= div_cnt_reg - STEP_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if ((cmd.op == OP_LD_ASY) || (cmd.op == OP_LD_NASY))
        begin
            div_rem_reg    <= ld_mag;
            div_den_reg    <= DIV_BITS'(ld_den);
            div_q_reg      <= '0;
            div_neg_reg    <= ld_num[DIV_BITS-1];
            div_ovf_reg    <= ld_mag >= DIV_BITS'(ld_den);
            div_forced_reg <= ld_forced;
            div_norm_reg   <= (cmd.op == OP_LD_NASY);
        end
        else if (cmd.op == OP_STEP)
        begin
            div_rem_reg <= ge ? rem2 - div_den_reg : rem2;
            div_q_reg   <= q_next;
            if (div_cnt_reg == STEP_BITS'(1))
            begin
                if (div_norm_reg)
                begin
                    nasy_reg <= q_res;
                end
                else
                begin
                    asy_reg <= q_res;
                end
            end
        end
    end

    // average divider, runs alongside the Q1.16 divides
    logic [DIFF_BITS-1:0] avg_sh_reg, sum_mag, avg_lim, avg_q;
    logic [NW-1:0]        avg_rem_reg;
    logic [NW:0]          avg_rem2;
    logic                 avg_ge, avg_neg_reg;
    logic [STEP_BITS-1:0] avg_cnt_reg;

    assign sum_mag  = sum_w[DIFF_BITS-1] ? DIFF_BITS'(-sum_w) : DIFF_BITS'(sum_w);
    assign avg_rem2 = {avg_rem_reg, avg_sh_reg[DIFF_BITS-1]};
    assign avg_ge   = avg_rem2 >= {1'b0, n_eff};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_cnt_reg <= '0;
        end
        else if (cmd.op == OP_MUL_A)
        begin
            avg_cnt_reg <= STEP_BITS'(AVG_STEPS);
        end
        else if (avg_cnt_reg != '0)
        begin
            avg_cnt_reg <= avg_cnt_reg - STEP_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_MUL_A)
        begin
            avg_sh_reg  <= sum_mag;
            avg_rem_reg <= '0;
            avg_neg_reg <= sum_w[DIFF_BITS-1];
        end
        else if (avg_cnt_reg != '0)
        begin
            avg_rem_reg <= avg_ge ? NW'(avg_rem2 - {1'b0, n_eff}) : NW'(avg_rem2);
            avg_sh_reg  <= {avg_sh_reg[DIFF_BITS-2:0], avg_ge};
        end
    end

    always_comb
    begin
        avg_lim = (DIFF_BITS'(1) << (AVG_BITS - 1)) - (avg_neg_reg ? '0 : DIFF_BITS'(1));
        avg_q   = (avg_sh_reg > avg_lim) ? avg_lim : avg_sh_reg;
    end

    // output word
    logic m_tvalid_reg;
    logic is_complete;

    assign is_complete   = (status_reg == ST_COMPLETE);
    assign stat.complete = is_complete;
    assign stat.div_last = (div_cnt_reg == STEP_BITS'(1));
    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.op == OP_OUT)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT)
        begin
            status          <= status_reg;
            difference      <= is_complete ? diff_w : '0;
            average_half    <= is_complete ?
                               AVG_BITS'(avg_neg_reg ? DIFF_BITS'(-avg_q) : avg_q) : '0;
            asymmetry       <= is_complete ? asy_reg : '0;
            norm_asymmetry  <= is_complete ? nasy_reg : '0;
            all_passed      <= is_complete && cuts_ok_reg;
            any_beam_cut    <= is_complete && beam_seen_reg;
            bad_denominator <= is_complete && (sum_w <= 0);
        end
    end

endmodule

[rtl/multiplet_asymmetry_accumulator.sv]
// Top level of the multiplet asymmetry accumulator.
//
//  port group  dir  handshake          contents
//  s_*         in   s_tvalid/s_tready  one right/left pair with monitors and flags
//  m_*         out  m_tvalid/m_tready  one result word per pair
//  cfg_*       in   cfg_we             pairs_per_multiplet
//
//  A pair that does not finish a multiplet goes from the check state to the output
//  state; one that finishes it first passes through the shared multiplier and two 16-step
//  Q1.16 divides sharing one divider, with the 28-step average divider running alongside.
//  The input is ready again in the same cycle that the result is shown.
//  rst_n asynchronously clears totals and beam flag, sets pass flag and register (to 2).
//  A new pair is taken while a result waits; a finished result holds until m_tready,
//  and the next result stalls the controller until then.
module multiplet_asymmetry_accumulator
    import maa_pkg::*;
#(
    parameter int MAX_PAIRS  = 8,
    parameter int VALUE_BITS = 24,
    localparam int IN_W      = ((4 * VALUE_BITS + 7) / 8) * 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // right_value, left_value, right_monitor, left_monitor
    input  logic [IN_W-1:0]           s_tdata,
    // first_mark, pair_passed, pair_beam_cut
    input  logic [IN_USER_BITS-1:0]   s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // difference, average_half, asymmetry, norm_asymmetry, all_passed,
    // any_beam_cut, bad_denominator
    output logic [OUT_DATA_BITS-1:0]  m_tdata,
    // status
    output logic [STATUS_BITS-1:0]    m_tuser,
    input  logic                      cfg_we,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    status_t                     status;
    logic signed [DIFF_BITS-1:0] difference;
    logic signed [AVG_BITS-1:0]  average_half;
    logic signed [Q_BITS-1:0]    asymmetry, norm_asymmetry;
    logic                        all_passed, any_beam_cut, bad_denominator;

    maa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    maa_datapath #(
        .MAX_PAIRS  (MAX_PAIRS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .first_mark      (s_tuser[0]),
        .right_value     (s_tdata[VALUE_BITS-1:0]),
        .left_value      (s_tdata[2*VALUE_BITS-1:VALUE_BITS]),
        .right_monitor   (s_tdata[3*VALUE_BITS-1:2*VALUE_BITS]),
        .left_monitor    (s_tdata[4*VALUE_BITS-1:3*VALUE_BITS]),
        .pair_passed     (s_tuser[1]),
        .pair_beam_cut   (s_tuser[2]),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .status          (status),
        .difference      (difference),
        .average_half    (average_half),
        .asymmetry       (asymmetry),
        .norm_asymmetry  (norm_asymmetry),
        .all_passed      (all_passed),
        .any_beam_cut    (any_beam_cut),
        .bad_denominator (bad_denominator)
    );

    assign m_tuser = status;
    assign m_tdata = {6'b0, bad_denominator, any_beam_cut, all_passed, norm_asymmetry,
                      asymmetry, average_half, difference};

endmodule

[rtl/maa_checker.sv]
// Port-level checks for the multiplet asymmetry accumulator, bound to the top level.
module maa_checker
    import maa_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [OUT_DATA_BITS-1:0]  m_tdata,
    input logic [STATUS_BITS-1:0]    m_tuser
);

    a_one_pair_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    a_partial_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_COMPLETE) |-> m_tdata == '0)
        else $error("incomplete result carries data");

    a_bad_den: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_COMPLETE) && m_tdata[89] |-> m_tdata[69:53] == Q_MINUS_ONE)
        else $error("bad denominator without minus one asymmetry");

endmodule

bind multiplet_asymmetry_accumulator maa_checker u_maa_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
